// ===== src/vrmm_pkg.sv =====
// shared types and constants for the version range major matcher
// no dependencies
`default_nettype none

package vrmm_pkg;

    localparam int WANTED_W = 17;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        PH_LO_MAJOR = 2'd0,
        PH_LO_MINOR = 2'd1,
        PH_HI_MAJOR = 2'd2,
        PH_HI_MINOR = 2'd3
    } phase_t;

    typedef struct packed {
        logic accepts;
        logic malformed;
    } result_t;

endpackage

`default_nettype wire

// ===== src/vrmm_parse.sv =====
// per-character parser state and its combinational next-state update
// depends on vrmm_pkg
`default_nettype none

module vrmm_parse #(
    parameter int VALUE_LIMIT = 100000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [7:0]                    char_code,
    input  wire logic                          last_char,
    input  wire logic                          no_char,
    input  wire logic [vrmm_pkg::WANTED_W-1:0] wanted_major,
    output vrmm_pkg::result_t                  result
);
    import vrmm_pkg::*;

    localparam int VAL_W = $clog2(VALUE_LIMIT + 1);
    localparam int PROD_W = VAL_W + 4;
    localparam int CMP_W = (VAL_W > WANTED_W) ? VAL_W : WANTED_W;
    localparam logic [VAL_W-1:0] LIMIT_V = VAL_W'(VALUE_LIMIT);

    phase_t           phase_reg, phase_next;
    logic             has_digit_reg, has_digit_next;
    logic [VAL_W-1:0] lo_maj_reg, lo_maj_next;
    logic [VAL_W-1:0] lo_min_reg, lo_min_next;
    logic [VAL_W-1:0] hi_maj_reg, hi_maj_next;
    logic [VAL_W-1:0] hi_min_reg, hi_min_next;
    logic             hit_reg, hit_next;
    logic             failed_reg, failed_next;

    logic [VAL_W-1:0]  cur;
    logic [VAL_W-1:0]  new_val;
    logic [PROD_W-1:0] prod;
    logic [3:0]        digit;
    logic [VAL_W-1:0]  c_hi_maj;
    logic [VAL_W-1:0]  c_hi_min;
    logic              c_fail;
    logic              c_hit;

    always_comb
    begin
        phase_next     = phase_reg;
        has_digit_next = has_digit_reg;
        lo_maj_next    = lo_maj_reg;
        lo_min_next    = lo_min_reg;
        hi_maj_next    = hi_maj_reg;
        hi_min_next    = hi_min_reg;
        hit_next       = hit_reg;
        failed_next    = failed_reg;
        result         = '0;
        c_fail         = 1'b0;
        c_hit          = 1'b0;
        c_hi_maj       = '0;
        c_hi_min       = '0;

        unique case (phase_reg)
            PH_LO_MAJOR: cur = lo_maj_reg;
            PH_LO_MINOR: cur = lo_min_reg;
            PH_HI_MAJOR: cur = hi_maj_reg;
            default:     cur = hi_min_reg;
        endcase
        digit = 4'(char_code - CHAR_ZERO);
        prod = (PROD_W'(cur) << 3) + (PROD_W'(cur) << 1) + PROD_W'(digit);
        new_val = (prod > PROD_W'(VALUE_LIMIT)) ? LIMIT_V : prod[VAL_W-1:0];

        // take the character
        if (!no_char)
        begin
            priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
            begin
                if (prod > PROD_W'(VALUE_LIMIT))
                    failed_next = 1'b1;
                has_digit_next = 1'b1;
                unique case (phase_reg)
                    PH_LO_MAJOR: lo_maj_next = new_val;
                    PH_LO_MINOR: lo_min_next = new_val;
                    PH_HI_MAJOR: hi_maj_next = new_val;
                    default:     hi_min_next = new_val;
                endcase
            end
            else if (char_code == CHAR_DOT)
            begin
                if (has_digit_reg && phase_reg == PH_LO_MAJOR)
                begin
                    phase_next     = PH_LO_MINOR;
                    has_digit_next = 1'b0;
                end
                else if (has_digit_reg && phase_reg == PH_HI_MAJOR)
                begin
                    phase_next     = PH_HI_MINOR;
                    has_digit_next = 1'b0;
                end
                else
                    failed_next = 1'b1;
            end
            else if (char_code == CHAR_DASH)
            begin
                if (has_digit_reg && phase_reg == PH_LO_MINOR)
                begin
                    phase_next     = PH_HI_MAJOR;
                    has_digit_next = 1'b0;
                end
                else
                    failed_next = 1'b1;
            end
            else if (char_code == CHAR_COMMA)
            begin
                // closed below, shared with end of list
            end
            else
                failed_next = 1'b1;
        end

        // close the range on a comma or at the end of the list
        if ((!no_char && char_code == CHAR_COMMA) || last_char)
        begin
            if (!has_digit_next ||
                (phase_next != PH_LO_MINOR && phase_next != PH_HI_MINOR))
                c_fail = 1'b1;
            else
            begin
                c_hi_maj = (phase_next == PH_LO_MINOR) ? lo_maj_next : hi_maj_next;
                c_hi_min = (phase_next == PH_LO_MINOR) ? lo_min_next : hi_min_next;
                if (lo_maj_next != c_hi_maj)
                    c_fail = 1'b1;
                if (c_hi_min < lo_min_next)
                    c_fail = 1'b1;
                if (CMP_W'(lo_maj_next) == CMP_W'(wanted_major))
                    c_hit = 1'b1;
            end
            // a comma on the final transaction leaves an empty range behind it
            if (!no_char && char_code == CHAR_COMMA && last_char)
                c_fail = 1'b1;
            failed_next    = failed_next | c_fail;
            hit_next       = hit_next | c_hit;
            phase_next     = PH_LO_MAJOR;
            has_digit_next = 1'b0;
            lo_maj_next    = '0;
            lo_min_next    = '0;
            hi_maj_next    = '0;
            hi_min_next    = '0;
        end

        if (last_char)
        begin
            result.malformed = failed_next;
            result.accepts   = !failed_next && hit_next;
            hit_next         = 1'b0;
            failed_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LO_MAJOR;
            has_digit_reg <= 1'b0;
            lo_maj_reg    <= '0;
            lo_min_reg    <= '0;
            hi_maj_reg    <= '0;
            hi_min_reg    <= '0;
            hit_reg       <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            has_digit_reg <= has_digit_next;
            lo_maj_reg    <= lo_maj_next;
            lo_min_reg    <= lo_min_next;
            hi_maj_reg    <= hi_maj_next;
            hi_min_reg    <= hi_min_next;
            hit_reg       <= hit_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/version_range_major_matcher_top.sv =====
// top level of the version range major matcher: input register, parser, result register
// depends on vrmm_pkg and vrmm_parse
//
// The input channel (in_valid/in_ready) carries one character of a
// comma-separated list of MAJOR.MINOR or MAJOR.MINOR-MAJOR.MINOR ranges per
// transaction; last_char marks the final transaction of a list and no_char
// a transaction that carries no byte (an empty list is one such transaction
// with last_char set).
// The output channel (out_valid/out_ready) carries one transaction per list,
// with accepts and malformed, produced by the transaction flagged last_char.
// wanted_major is written by cfg_write; reset value 1. The user must write it only
// while the block is idle; the block itself does not enforce this. A result passes
// through the input register, then the parser update into the result register.
// Throughput: one character per cycle, but a final character waits while the result
// register is full; the parser state update is a single multiply-by-ten accumulate and
// compare between the two registers. Reset clears the parser state and the valid flags
// of the input and result registers. When the receiver stalls, the result is held;
// non-final characters keep flowing, and a following final character waits in the input
// register until the result register is free.
`default_nettype none

module version_range_major_matcher_top #(
    parameter int VALUE_LIMIT = 100000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [7:0]                    char_code,
    input  wire logic                          last_char,
    input  wire logic                          no_char,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic                          accepts,
    output      logic                          malformed,
    input  wire logic                          cfg_write,
    input  wire logic [vrmm_pkg::WANTED_W-1:0] wanted_major
);
    import vrmm_pkg::*;

    logic                s1_valid_reg;
    logic [7:0]          s1_char_reg;
    logic                s1_last_reg;
    logic                s1_none_reg;
    logic [WANTED_W-1:0] wanted_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                s1_go;
    logic                step;
    result_t             res;

    assign s1_go    = !s1_last_reg || !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && s1_go;
    assign in_ready = !s1_valid_reg || s1_go;

    vrmm_parse #(
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_code    (s1_char_reg),
        .last_char    (s1_last_reg),
        .no_char      (s1_none_reg),
        .wanted_major (wanted_reg),
        .result       (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
            s1_none_reg <= no_char;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_reg <= WANTED_W'(1);
        else if (cfg_write)
            wanted_reg <= wanted_major;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign accepts   = out_reg.accepts;
    assign malformed = out_reg.malformed;

endmodule

`default_nettype wire

// ===== test/version_range_major_matcher_top_tb.sv =====
// testbench for version_range_major_matcher_top: directed and random range lists
// checked against a behavioral parser model; depends on vrmm_pkg and the block's rtl
module version_range_major_matcher_top_tb;

    import vrmm_pkg::*;

    localparam int VALUE_MAX      = 100000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          char_code;
    logic                last_char;
    logic                no_char;
    logic                out_valid;
    logic                out_ready;
    logic                accepts;
    logic                malformed;
    logic                cfg_write;
    logic [WANTED_W-1:0] wanted_major;

    // parser model state
    phase_t              lst_phase;
    logic                lst_has_digit;
    logic [WANTED_W-1:0] lst_lo_major;
    logic [WANTED_W-1:0] lst_lo_minor;
    logic [WANTED_W-1:0] lst_hi_major;
    logic [WANTED_W-1:0] lst_hi_minor;
    logic                lst_hit;
    logic                lst_bad;
    logic [WANTED_W-1:0] cur_wanted;

    result_t verdict_q[$];

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int items_sent;
    int err_count;
    int idle_cycles;

    version_range_major_matcher_top #(
        .VALUE_LIMIT(VALUE_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .char_code(char_code),
        .last_char(last_char),
        .no_char(no_char),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .accepts(accepts),
        .malformed(malformed),
        .cfg_write(cfg_write),
        .wanted_major(wanted_major)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- parser model ----------------

    task automatic close_range();
        if (!lst_has_digit || (lst_phase != PH_LO_MINOR && lst_phase != PH_HI_MINOR))
            lst_bad = 1'b1;
        else
        begin
            if (lst_phase == PH_LO_MINOR)
            begin
                lst_hi_major = lst_lo_major;
                lst_hi_minor = lst_lo_minor;
            end
            if (lst_lo_major != lst_hi_major)
                lst_bad = 1'b1;
            if (lst_hi_minor < lst_lo_minor)
                lst_bad = 1'b1;
            if (lst_lo_major == cur_wanted)
                lst_hit = 1'b1;
        end
        lst_phase     = PH_LO_MAJOR;
        lst_has_digit = 1'b0;
        lst_lo_major  = '0;
        lst_lo_minor  = '0;
        lst_hi_major  = '0;
        lst_hi_minor  = '0;
    endtask

    task automatic take_char(input logic [7:0] c);
        int v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            case (lst_phase)
                PH_LO_MAJOR: v = int'(lst_lo_major);
                PH_LO_MINOR: v = int'(lst_lo_minor);
                PH_HI_MAJOR: v = int'(lst_hi_major);
                default:     v = int'(lst_hi_minor);
            endcase
            v = v * 10 + int'(c - CHAR_ZERO);
            if (v > VALUE_MAX)
            begin
                v = VALUE_MAX;
                lst_bad = 1'b1;
            end
            case (lst_phase)
                PH_LO_MAJOR: lst_lo_major = WANTED_W'(v);
                PH_LO_MINOR: lst_lo_minor = WANTED_W'(v);
                PH_HI_MAJOR: lst_hi_major = WANTED_W'(v);
                default:     lst_hi_minor = WANTED_W'(v);
            endcase
            lst_has_digit = 1'b1;
        end
        else if (c == CHAR_DOT)
        begin
            if (lst_has_digit && (lst_phase == PH_LO_MAJOR || lst_phase == PH_HI_MAJOR))
            begin
                lst_phase     = phase_t'(lst_phase + 2'd1);
                lst_has_digit = 1'b0;
            end
            else
                lst_bad = 1'b1;
        end
        else if (c == CHAR_DASH)
        begin
            if (lst_has_digit && lst_phase == PH_LO_MINOR)
            begin
                lst_phase     = PH_HI_MAJOR;
                lst_has_digit = 1'b0;
            end
            else
                lst_bad = 1'b1;
        end
        else if (c == CHAR_COMMA)
            close_range();
        else
            lst_bad = 1'b1;
    endtask

    task automatic predict_verdict(input logic [7:0] c, input logic lst, input logic nc);
        result_t v;
        if (!nc)
            take_char(c);
        if (lst)
        begin
            close_range();
            v.malformed = lst_bad;
            v.accepts   = !lst_bad && lst_hit;
            verdict_q   = {verdict_q, v};
            lst_hit = 1'b0;
            lst_bad = 1'b0;
        end
    endtask

    // ---------------- drivers ----------------

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [7:0] c, input logic lst, input logic nc);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= lst;
        no_char   <= nc;
        do
            @(posedge clk);
        while (!in_ready);
        predict_verdict(c, lst, nc);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_list(input string s, input bit tail_none);
        int n;
        n = s.len();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(s[i], !tail_none && i == n - 1, 1'b0);
        end
        if (n == 0 || tail_none)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_wanted(input logic [WANTED_W-1:0] v);
        drain_results();
        cfg_write    <= 1'b1;
        wanted_major <= v;
        @(negedge clk);
        cfg_write  <= 1'b0;
        cur_wanted = v;
    endtask

    // ---------------- random list generation ----------------

    function automatic int rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 12);
        if (r < 93)
            return $urandom_range(0, 99999);
        return $urandom_range(99990, 1500000);
    endfunction

    function automatic string rand_range();
        int maj;
        int lo;
        int hi;
        int hi_maj;
        maj = ($urandom_range(0, 9) < 4) ? int'(cur_wanted) : rand_value();
        lo  = rand_value();
        if ($urandom_range(0, 1) == 0)
            return $sformatf("%0d.%0d", maj, lo);
        hi     = ($urandom_range(0, 4) != 0) ? lo + $urandom_range(0, 5) : rand_value();
        hi_maj = ($urandom_range(0, 9) != 0) ? maj : rand_value();
        return $sformatf("%0d.%0d-%0d.%0d", maj, lo, hi_maj, hi);
    endfunction

    function automatic string noise_char();
        string c;
        c = "0";
        case ($urandom_range(0, 4))
            0:       c[0] = 8'(CHAR_ZERO + $urandom_range(0, 9));
            1:       c[0] = CHAR_DOT;
            2:       c[0] = CHAR_DASH;
            3:       c[0] = CHAR_COMMA;
            default: c[0] = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    function automatic string rand_list();
        string s;
        int r;
        int n;
        int pos;
        r = $urandom_range(0, 99);
        if (r < 5)
            return "";
        s = "";
        if (r < 15)
        begin
            n = $urandom_range(1, 8);
            repeat (n) s = {s, noise_char()};
            return s;
        end
        n = $urandom_range(1, 3);
        s = rand_range();
        repeat (n - 1) s = {s, ",", rand_range()};
        // broken variants of a well-formed list
        if (r < 30)
        begin
            pos = $urandom_range(0, s.len() - 1);
            case ($urandom_range(0, 4))
                0:       s[pos] = CHAR_DOT;
                1:       s[pos] = CHAR_DASH;
                2:       s[pos] = CHAR_COMMA;
                3:       s = {",", s};
                default: s = {s, ","};
            endcase
        end
        return s;
    endfunction

    // ---------------- receiver, checker, watchdog ----------------

    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = RX_HOLD_CYCLES;
            end
            else if (stall == 0 && rx_idle_on)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected transaction: accepts %0b malformed %0b", accepts, malformed);
                err_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (accepts !== want.accepts)
                begin
                    $error("accepts: expected %0b, actual %0b", want.accepts, accepts);
                    err_count++;
                end
                if (malformed !== want.malformed)
                begin
                    $error("malformed: expected %0b, actual %0b", want.malformed, malformed);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_basic_lists();
        send_list("", 1'b0);
        send_list("1.0", 1'b0);
        send_list("1.2-1.3", 1'b0);
        send_list("1.0", 1'b1);
        send_list("2.0,1.5", 1'b0);
        send_list("2.0", 1'b0);
    endtask

    task automatic test_bad_ranges();
        send_list("1.3-1.2", 1'b0);
        send_list("1.0-2.0", 1'b0);
        send_list("1-2", 1'b0);
        send_list(".1", 1'b0);
        send_list("1..2", 1'b0);
        send_list("1.2-.3", 1'b0);
        send_list("1.2-1", 1'b0);
    endtask

    task automatic test_commas();
        send_list(",1.0", 1'b0);
        send_list("1.0,,2.0", 1'b0);
        send_list("1.0,", 1'b0);
    endtask

    task automatic test_foreign_bytes();
        send_list("1.x", 1'b0);
        send_item(CHAR_ZERO + 8'd1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
    endtask

    task automatic test_value_limits();
        send_list("100001.0", 1'b0);
        send_list("999999999.0-1.0", 1'b0);
        set_wanted(WANTED_W'(VALUE_MAX));
        send_list("100000.5-100000.99999", 1'b0);
        set_wanted(WANTED_W'(0));
        send_list("00.7-0.9", 1'b0);
        set_wanted(WANTED_W'(1));
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        repeat (6)
        begin
            send_list("1.2,3.4", 1'b0);
            send_list("7.1", 1'b0);
        end
        drain_results();
    endtask

    task automatic test_random_lists();
        int lists;
        int stop_at;
        int r;
        lists   = 0;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if (lists % 40 == 0)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    set_wanted(WANTED_W'(0));
                else if (r == 1)
                    set_wanted(WANTED_W'(VALUE_MAX));
                else if (r < 4)
                    set_wanted(WANTED_W'($urandom_range(0, VALUE_MAX)));
                else
                    set_wanted(WANTED_W'($urandom_range(0, 12)));
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_list(rand_list(), $urandom_range(0, 9) == 0);
            lists++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_code     = '0;
        last_char     = 1'b0;
        no_char       = 1'b0;
        cfg_write     = 1'b0;
        wanted_major  = WANTED_W'(1);
        cur_wanted    = WANTED_W'(1);
        lst_phase     = PH_LO_MAJOR;
        lst_has_digit = 1'b0;
        lst_lo_major  = '0;
        lst_lo_minor  = '0;
        lst_hi_major  = '0;
        lst_hi_minor  = '0;
        lst_hit       = 1'b0;
        lst_bad       = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        items_sent    = 0;
        err_count     = 0;
        idle_cycles   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_lists();
        test_bad_ranges();
        test_commas();
        test_foreign_bytes();
        test_value_limits();
        test_backpressure();
        test_random_lists();

        drain_results();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
